// ----- sv/assert_macros.svh -----
// assertion macros for the rtl files, included by rcfs_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ----- sv/rcfs_pkg.sv -----
// types and constants for the rgb color fade stepper
package rcfs_pkg;

	localparam int CHAN_W    = 8;
	localparam int NUM_CHAN  = 3;
	localparam int COLOR_W   = CHAN_W * NUM_CHAN;
	localparam int PROD_W    = 2 * CHAN_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int IDX_W     = 1;

	localparam logic [IDX_W-1:0] CFG_START_COLOR = 1'b0;
	localparam logic [IDX_W-1:0] CFG_END_COLOR   = 1'b1;

	typedef struct packed {
		logic              start;
		logic              iterate;
		logic              load_out;
		logic              last;
		logic [CHAN_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic [CHAN_W-1:0] n;
	} stat_t;

endpackage

// ----- sv/rcfs_datapath.sv -----
// config registers, step count, per-channel multiply and restoring divide, output register
module rcfs_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rcfs_pkg::IDX_W-1:0]     cfg_idx,
	input  logic [rcfs_pkg::COLOR_W-1:0]   cfg_wdata,
	input  rcfs_pkg::cmd_t                 cmd,
	output rcfs_pkg::stat_t                stat,
	output logic [rcfs_pkg::COLOR_W-1:0]   frame_color,
	output logic [rcfs_pkg::CHAN_W-1:0]    step_index,
	output logic                           last_step
);

	localparam int CW = rcfs_pkg::CHAN_W;
	localparam int PW = rcfs_pkg::PROD_W;
	localparam int NC = rcfs_pkg::NUM_CHAN;

	logic [rcfs_pkg::COLOR_W-1:0] start_q;
	logic [rcfs_pkg::COLOR_W-1:0] end_q;
	logic [CW-1:0]                ad_w [NC];
	logic [CW-1:0]                chan_w [NC];
	logic [CW-1:0]                max_rg;
	logic [CW-1:0]                n_w;
	logic [rcfs_pkg::COLOR_W-1:0] frame_q;
	logic [CW-1:0]                step_q;
	logic                         last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				rcfs_pkg::CFG_START_COLOR: start_q <= cfg_wdata;
				rcfs_pkg::CFG_END_COLOR:   end_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	for (genvar c = 0; c < NC; c++) begin : g_lane
		logic [CW-1:0] s;
		logic [CW-1:0] e;
		logic          up;
		logic [CW:0]   trial;
		logic [CW:0]   diff;
		logic          ge;
		logic [CW-1:0] rem_q;
		logic [PW-1:0] div_q;

		assign s     = start_q[c*CW +: CW];
		assign e     = end_q[c*CW +: CW];
		assign up    = (e >= s);
		assign ad_w[c] = up ? (e - s) : (s - e);
		assign trial = {rem_q, div_q[PW-1]};
		assign diff  = trial - {1'b0, n_w};
		assign ge    = (trial >= {1'b0, n_w});
		assign chan_w[c] = up ? (s + div_q[CW-1:0]) : (s - div_q[CW-1:0]);

		always_ff @(posedge clk) begin
			if (cmd.start) begin
				div_q <= {{CW{1'b0}}, ad_w[c]} * {{CW{1'b0}}, cmd.step};
				rem_q <= '0;
			end else if (cmd.iterate) begin
				rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
				div_q <= {div_q[PW-2:0], ge};
			end
		end
	end

	assign max_rg = (ad_w[1] > ad_w[0]) ? ad_w[1] : ad_w[0];
	assign n_w    = (ad_w[2] > max_rg) ? ad_w[2] : max_rg;
	assign stat.n = n_w;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			frame_q <= {chan_w[2], chan_w[1], chan_w[0]};
			step_q  <= cmd.step;
			last_q  <= cmd.last;
		end
	end

	assign frame_color = frame_q;
	assign step_index  = step_q;
	assign last_step   = last_q;

endmodule

// ----- sv/rcfs_ctrl.sv -----
// fade controller: step and done tracking, divide sequencing, request handshakes
`include "assert_macros.svh"

module rcfs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            restart,
	output logic            out_valid,
	input  logic            out_ready,
	output rcfs_pkg::cmd_t  cmd,
	input  rcfs_pkg::stat_t stat
);

	localparam int CW = rcfs_pkg::CHAN_W;
	localparam logic [rcfs_pkg::CNT_W-1:0] CNT_LAST = rcfs_pkg::CNT_W'(rcfs_pkg::DIV_STEPS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                     state_q;
	logic [rcfs_pkg::CNT_W-1:0] cnt_q;
	logic [CW-1:0]              step_q;
	logic                       done_q;
	logic                       out_valid_q;

	logic          in_fire;
	logic          eff_done;
	logic [CW-1:0] eff_step;
	logic          frame_ok;
	logic          slot_free;
	logic          is_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign eff_done  = restart ? 1'b0 : done_q;
	assign eff_step  = restart ? '0 : step_q;
	assign frame_ok  = !eff_done && (eff_step < stat.n);
	assign slot_free = !out_valid_q || out_ready;
	assign is_last   = (({1'b0, step_q} + (CW+1)'(1)) == {1'b0, stat.n});

	always_comb begin
		cmd          = '0;
		cmd.start    = in_fire && frame_ok;
		cmd.iterate  = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_FIN) && slot_free;
		cmd.last     = is_last;
		cmd.step     = cmd.start ? eff_step : step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			step_q      <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (frame_ok) begin
							step_q  <= eff_step;
							done_q  <= 1'b0;
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end else begin
							step_q <= eff_step;
							done_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) begin
						if (is_last)
							done_q <= 1'b1;
						else
							step_q <= step_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_CLK(a_div_ends, clk, arst_n, (state_q == ST_DIV && cnt_q == CNT_LAST) |=> (state_q == ST_FIN))
	`ASSERT_CLK(a_start_in_range, clk, arst_n, cmd.start |-> (cmd.step < stat.n))
	`ASSERT_CLK(a_last_sets_done, clk, arst_n, (cmd.load_out && cmd.last) |=> done_q)
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.load_out && out_valid_q && !out_ready)

endmodule

// ----- sv/rgb_color_fade_stepper_top.sv -----
// top level of the rgb color fade stepper: controller plus datapath
// a frame runs ST_DIV, then ST_FIN (waits for a free output), then out_valid rises
// frames go one at a time through the 16-step restoring dividers, one per channel
// a request that makes no frame only updates step and done; in_ready is low while a frame is in work
// reset (arst_n low, asynchronous): colors, step and done cleared, no result pending
module rgb_color_fade_stepper_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rcfs_pkg::IDX_W-1:0]     cfg_idx,
	input  logic [rcfs_pkg::COLOR_W-1:0]   cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rcfs_pkg::COLOR_W-1:0]   frame_color,
	output logic [rcfs_pkg::CHAN_W-1:0]    step_index,
	output logic                           last_step
);

	rcfs_pkg::cmd_t  cmd;
	rcfs_pkg::stat_t stat;

	rcfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	rcfs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.stat        (stat),
		.frame_color (frame_color),
		.step_index  (step_index),
		.last_step   (last_step)
	);

endmodule

// ----- verif/rgb_color_fade_stepper_top_test.sv -----
// self-checking testbench for the rgb color fade stepper: directed table, then random fades
`timescale 1ns / 100ps

module rgb_color_fade_stepper_top_test;

	localparam int COLOR_W = rcfs_pkg::COLOR_W;
	localparam int CHAN_W  = rcfs_pkg::CHAN_W;
	localparam int IDX_W   = rcfs_pkg::IDX_W;
	localparam int PROD_W  = rcfs_pkg::PROD_W;
	localparam logic [IDX_W-1:0] CFG_START_COLOR = rcfs_pkg::CFG_START_COLOR;
	localparam logic [IDX_W-1:0] CFG_END_COLOR   = rcfs_pkg::CFG_END_COLOR;

	localparam int RAND_TICKS  = 1200;
	localparam int QUIET_AFTER = 1050;
	localparam int HOLD_OFF    = 24;
	localparam int STALL_LIMIT = 4000;
	localparam int NUM_ROWS    = 29;

	typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

	typedef struct {
		logic [COLOR_W-1:0] color;
		logic [CHAN_W-1:0]  step;
		logic               last;
	} frame_t;

	typedef struct {
		row_kind_t          kind;
		logic [IDX_W-1:0]   idx;
		logic [COLOR_W-1:0] data;
		bit                 typed;
		bit                 has_frame;
		logic [COLOR_W-1:0] color;
		logic [CHAN_W-1:0]  step;
		logic               last;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_idx;
	logic [COLOR_W-1:0] cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic               restart;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COLOR_W-1:0] frame_color;
	logic [CHAN_W-1:0]  step_index;
	logic               last_step;

	// shadow of the block: registers and fade position
	logic [COLOR_W-1:0] start_reg;
	logic [COLOR_W-1:0] end_reg;
	logic [CHAN_W-1:0]  cur_step;
	bit                 fade_over;

	frame_t frames_due[$];
	frame_t head;
	row_t   plan[NUM_ROWS];

	int  errors = 0;
	int  frames_checked = 0;
	int  ticks_sent = 0;
	int  reg_writes = 0;
	int  idle_cycles = 0;
	int  stall_left = 0;
	bit  quiet = 1'b0;

	rgb_color_fade_stepper_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_color(frame_color),
		.step_index(step_index),
		.last_step(last_step)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [CHAN_W-1:0] chan_dist(input logic [CHAN_W-1:0] a, b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] s, e, i, n);
		logic [PROD_W-1:0] mag;
		mag = ({8'd0, chan_dist(s, e)} * {8'd0, i}) / {8'd0, n};
		return (e >= s) ? s + mag[CHAN_W-1:0] : s - mag[CHAN_W-1:0];
	endfunction

	// advances the shadow fade by one tick, returns 1 when a frame comes out
	function automatic bit fade_tick(input logic rst_req, output frame_t f);
		logic [CHAN_W-1:0] sg, sr, sb, eg, er, eb, n;
		sg = start_reg[23:16];
		sr = start_reg[15:8];
		sb = start_reg[7:0];
		eg = end_reg[23:16];
		er = end_reg[15:8];
		eb = end_reg[7:0];
		f.color = '0;
		f.step = '0;
		f.last = 1'b0;
		if (rst_req) begin
			cur_step = '0;
			fade_over = 1'b0;
		end
		n = chan_dist(sr, er);
		if (chan_dist(sg, eg) > n) n = chan_dist(sg, eg);
		if (chan_dist(sb, eb) > n) n = chan_dist(sb, eb);
		if (fade_over || cur_step >= n) begin
			fade_over = 1'b1;
			return 1'b0;
		end
		f.color = {blend(sg, eg, cur_step, n), blend(sr, er, cur_step, n),
			blend(sb, eb, cur_step, n)};
		f.step = cur_step;
		f.last = (cur_step + 8'd1 == n);
		if (f.last) fade_over = 1'b1;
		else cur_step = cur_step + 8'd1;
		return 1'b1;
	endfunction

	function automatic logic [CHAN_W-1:0] near_chan(input logic [CHAN_W-1:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 12)) - 6;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[CHAN_W-1:0];
	endfunction

	// called at a falling edge; waits for the block to go idle, then writes
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
		in_valid = 1'b0;
		while (frames_due.size() != 0) @(negedge clk);
		repeat (HOLD_OFF) @(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = data;
		if (idx == CFG_START_COLOR) start_reg = data;
		else end_reg = data;
		reg_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_tick(input logic r, input bit typed, input bit want_frame,
		input frame_t want);
		frame_t f;
		bit has;
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		restart = r;
		do @(posedge clk); while (!in_ready);
		has = fade_tick(r, f);
		if (typed) begin
			if (want_frame) frames_due.push_back(want);
		end else if (has) begin
			frames_due.push_back(f);
		end
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic pick_colors(output logic [COLOR_W-1:0] s, e);
		s = COLOR_W'($urandom);
		case ($urandom_range(0, 9))
			0: begin
				e = COLOR_W'($urandom);
			end
			1: begin
				e = s;
			end
			2: begin
				s = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
				e = $urandom_range(0, 1) ? ~s : s ^ 24'hFF00FF;
			end
			default: begin
				e = {near_chan(s[23:16]), near_chan(s[15:8]), near_chan(s[7:0])};
			end
		endcase
	endtask

	// out_ready stalls in random bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 13);
			out_ready = 1'b0;
		end else begin
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (frames_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected frame: color %h step %0d last %b",
						$time, frame_color, step_index, last_step);
				end else begin
					head = frames_due.pop_front();
					frames_checked++;
					if (frame_color !== head.color) begin
						errors++;
						$display("%0t: frame_color expected %h actual %h",
							$time, head.color, frame_color);
					end
					if (step_index !== head.step) begin
						errors++;
						$display("%0t: step_index expected %0d actual %0d",
							$time, head.step, step_index);
					end
					if (last_step !== head.last) begin
						errors++;
						$display("%0t: last_step expected %b actual %b",
							$time, head.last, last_step);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d frames outstanding",
					$time, idle_cycles, frames_due.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [COLOR_W-1:0] s, e;
		frame_t want;
		int n_ticks, mode, k, rand_ticks;
		logic r;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_START_COLOR;
		cfg_wdata = '0;
		in_valid = 1'b0;
		restart = 1'b0;
		start_reg = '0;
		end_reg = '0;
		cur_step = '0;
		fade_over = 1'b0;

		plan = '{
			// after reset the colors are equal, so nothing comes out
			'{ROW_TICK, CFG_START_COLOR, 24'h000000, 1, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_CFG,  CFG_START_COLOR, 24'h000000, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_CFG,  CFG_END_COLOR,   24'hFFFFFF, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000001, 1, 1, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000000, 1, 1, 24'h010101, 8'd1, 1'b0},
			// colors swapped mid-fade
			'{ROW_CFG,  CFG_START_COLOR, 24'hFFFFFF, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_CFG,  CFG_END_COLOR,   24'h000000, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000000, 0, 0, 24'h000000, 8'd0, 1'b0},
			// one-step fade, then done, then restart while done
			'{ROW_CFG,  CFG_START_COLOR, 24'h102030, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_CFG,  CFG_END_COLOR,   24'h112030, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000001, 1, 1, 24'h102030, 8'd0, 1'b1},
			'{ROW_TICK, CFG_START_COLOR, 24'h000000, 1, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000001, 1, 1, 24'h102030, 8'd0, 1'b1},
			// equal colors
			'{ROW_CFG,  CFG_END_COLOR,   24'h102030, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000001, 1, 0, 24'h000000, 8'd0, 1'b0},
			// channels moving in opposite directions
			'{ROW_CFG,  CFG_START_COLOR, 24'h00FF00, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_CFG,  CFG_END_COLOR,   24'hFF0080, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000001, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000000, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000000, 0, 0, 24'h000000, 8'd0, 1'b0},
			// step count shrinks below the current step mid-fade
			'{ROW_CFG,  CFG_START_COLOR, 24'h000000, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_CFG,  CFG_END_COLOR,   24'h000002, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000000, 1, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000001, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000000, 0, 0, 24'h000000, 8'd0, 1'b0},
			// mixed directions, uneven distances
			'{ROW_CFG,  CFG_START_COLOR, 24'h804020, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_CFG,  CFG_END_COLOR,   24'h20A0FF, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000001, 0, 0, 24'h000000, 8'd0, 1'b0},
			'{ROW_TICK, CFG_START_COLOR, 24'h000000, 0, 0, 24'h000000, 8'd0, 1'b0}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (k = 0; k < NUM_ROWS; k++) begin
			if (plan[k].kind == ROW_CFG) begin
				write_reg(plan[k].idx, plan[k].data);
			end else begin
				want.color = plan[k].color;
				want.step = plan[k].step;
				want.last = plan[k].last;
				send_tick(plan[k].data[0], plan[k].typed, plan[k].has_frame, want);
			end
		end

		want.color = '0;
		want.step = '0;
		want.last = 1'b0;
		rand_ticks = 0;
		while (rand_ticks < RAND_TICKS) begin
			pick_colors(s, e);
			mode = $urandom_range(0, 3);
			if (mode != 1) write_reg(CFG_START_COLOR, s);
			if (mode != 0) write_reg(CFG_END_COLOR, e);
			n_ticks = $urandom_range(10, 50);
			for (k = 0; k < n_ticks; k++) begin
				if (k == 0) r = ($urandom_range(0, 3) != 0);
				else r = ($urandom_range(0, 15) == 0);
				// hold the next request until the block has drained
				if ($urandom_range(0, 31) == 0) begin
					in_valid = 1'b0;
					while (frames_due.size() != 0) @(negedge clk);
				end
				send_tick(r, 0, 0, want);
				rand_ticks++;
				if (rand_ticks >= QUIET_AFTER) quiet = 1'b1;
			end
		end

		in_valid = 1'b0;
		while (frames_due.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);

		$display("run covered %0d ticks and %0d register writes, %0d frames checked",
			ticks_sent, reg_writes, frames_checked);
		$display("fades included equal colors, extremes, restarts and mid-fade color changes");
		if (errors == 0 && frames_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/rcfs_pkg.sv
sv/rcfs_datapath.sv
sv/rcfs_ctrl.sv
sv/rgb_color_fade_stepper_top.sv
verif/rgb_color_fade_stepper_top_test.sv
